// File: hdl/assert_macros.svh
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv assertion failed");

`endif

// File: hdl/r2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2h_pkg: shared types and constants
// Widths of the pixel and result fields and the word passed along the
// divider chain.
// ----------------------------------------------------------------------------
package r2h_pkg;

  localparam int unsigned ChW      = 8;   // color channel width
  localparam int unsigned HueW     = 16;  // hue fraction width
  localparam int unsigned HueDivW  = 11;  // 6*d fits below 2^11
  localparam int unsigned SatNumW  = 16;  // 255*d fits below 2^16
  localparam int unsigned NumCells = 16;  // one quotient bit per cell

  // Word handed from cell to cell: two restoring dividers side by side.
  typedef struct packed {
    logic [HueDivW-1:0] hue_rem;
    logic [HueW-1:0]    hue_quo;   // quotient bits shift in at the bottom
    logic [HueDivW-1:0] hue_div;
    logic [ChW-1:0]     sat_rem;
    logic [SatNumW-1:0] sat_quo;   // dividend shifts out, quotient shifts in
    logic [ChW-1:0]     sat_div;
    logic [ChW-1:0]     value;
  } div_t;

endpackage

// File: hdl/r2h_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2h_front: max/min and dividend setup
// Finds the largest and smallest channel, forms the hue numerator and
// divisor and the saturation dividend, and registers them for the chain.
// ----------------------------------------------------------------------------
module r2h_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     up_vld_i,
  output logic                     up_rdy_o,
  input  logic [r2h_pkg::ChW-1:0]  red_i,
  input  logic [r2h_pkg::ChW-1:0]  green_i,
  input  logic [r2h_pkg::ChW-1:0]  blue_i,
  output logic                     dn_vld_o,
  input  logic                     dn_rdy_i,
  output r2h_pkg::div_t            dn_dat_o
);

  localparam int unsigned PadW = r2h_pkg::HueDivW - r2h_pkg::ChW;

  logic                          vld_q, vld_d;
  r2h_pkg::div_t                 dat_q, dat_d;
  logic                          red_max, green_max;
  logic [r2h_pkg::ChW-1:0]       mx, mn, d;
  logic [r2h_pkg::HueDivW-1:0]   r11, g11, b11, d11, six_d, num;
  logic [r2h_pkg::SatNumW-1:0]   d16, sat_num;

  assign up_rdy_o = !vld_q || dn_rdy_i;

  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      mx = red_i;
    end else if (green_max) begin
      mx = green_i;
    end else begin
      mx = blue_i;
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;

    r11   = {{PadW{1'b0}}, red_i};
    g11   = {{PadW{1'b0}}, green_i};
    b11   = {{PadW{1'b0}}, blue_i};
    d11   = {{PadW{1'b0}}, d};
    six_d = (d11 << 2) + (d11 << 1);

    // Sum stays in [0, 6d), so modulo arithmetic here is exact.
    if (red_max) begin
      num = (g11 - b11) + ((green_i < blue_i) ? six_d : '0);
    end else if (green_max) begin
      num = (b11 - r11) + (d11 << 1);
    end else begin
      num = (r11 - g11) + (d11 << 2);
    end

    d16     = {{(r2h_pkg::SatNumW - r2h_pkg::ChW){1'b0}}, d};
    sat_num = (d16 << 8) - d16;

    dat_d = dat_q;
    vld_d = vld_q;
    if (up_rdy_o) begin
      vld_d = up_vld_i;
      if (up_vld_i) begin
        // Achromatic: numerator is zero, so a unit divisor yields zero.
        dat_d.hue_rem = (d == '0) ? '0 : num;
        dat_d.hue_quo = '0;
        dat_d.hue_div = (d == '0) ? r2h_pkg::HueDivW'(1) : six_d;
        // Black: dividend is zero, so a unit divisor yields zero.
        dat_d.sat_rem = '0;
        dat_d.sat_quo = sat_num;
        dat_d.sat_div = (mx == '0) ? r2h_pkg::ChW'(1) : mx;
        dat_d.value   = mx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

  assign dn_vld_o = vld_q;
  assign dn_dat_o = dat_q;

endmodule

// File: hdl/r2h_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2h_cell: one divider step
// Produces one hue quotient bit and one saturation quotient bit per beat,
// with its own valid and a ready that lets bubbles collapse.
// ----------------------------------------------------------------------------
module r2h_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_vld_i,
  output logic          up_rdy_o,
  input  r2h_pkg::div_t up_dat_i,
  output logic          dn_vld_o,
  input  logic          dn_rdy_i,
  output r2h_pkg::div_t dn_dat_o
);

  logic                          vld_q, vld_d;
  r2h_pkg::div_t                 dat_q, dat_d;
  logic [r2h_pkg::HueDivW:0]     hue_t;
  logic [r2h_pkg::ChW:0]         sat_t;
  logic                          hue_ge, sat_ge;

  assign up_rdy_o = !vld_q || dn_rdy_i;

  always_comb begin
    hue_t  = {up_dat_i.hue_rem, up_dat_i.hue_quo[r2h_pkg::HueW-1]};
    hue_ge = hue_t >= {1'b0, up_dat_i.hue_div};
    sat_t  = {up_dat_i.sat_rem, up_dat_i.sat_quo[r2h_pkg::SatNumW-1]};
    sat_ge = sat_t >= {1'b0, up_dat_i.sat_div};

    vld_d = vld_q;
    dat_d = dat_q;
    if (up_rdy_o) begin
      vld_d = up_vld_i;
      if (up_vld_i) begin
        dat_d = up_dat_i;
        dat_d.hue_rem = hue_ge ? r2h_pkg::HueDivW'(hue_t - {1'b0, up_dat_i.hue_div})
                               : r2h_pkg::HueDivW'(hue_t);
        dat_d.hue_quo = {up_dat_i.hue_quo[r2h_pkg::HueW-2:0], hue_ge};
        dat_d.sat_rem = sat_ge ? r2h_pkg::ChW'(sat_t - {1'b0, up_dat_i.sat_div})
                               : r2h_pkg::ChW'(sat_t);
        dat_d.sat_quo = {up_dat_i.sat_quo[r2h_pkg::SatNumW-2:0], sat_ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

  assign dn_vld_o = vld_q;
  assign dn_dat_o = dat_q;

endmodule

// File: hdl/rgb_to_hsv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv: RGB pixel to hue, saturation, value
// Pipelined conversion of 8-bit RGB pixels to 16-bit hue and 8-bit S and V.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries red_i, green_i, blue_i.
//   Output channel out_valid_o/out_ready_i carries hue_o, saturation_o,
//   value_o, one result beat per input beat, in order.
//   The pipeline is one setup stage (max, min, dividends) and a row
//   of 16 divider cells, each retiring one bit of both quotients.
//   Throughput is one pixel per cycle while the receiver keeps up; the
//   row of cells sets that figure, as every cell takes a new beat each cycle.
//   Each stage holds its own valid bit, so when the receiver stalls the
//   results stack up at the tail and empty stages still take new pixels;
//   in_ready_o drops only once all 17 stages hold a beat.
//   Reset clears all valid bits; the pipeline is empty and ready after it.
// ----------------------------------------------------------------------------
module rgb_to_hsv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [r2h_pkg::ChW-1:0]   red_i,
  input  logic [r2h_pkg::ChW-1:0]   green_i,
  input  logic [r2h_pkg::ChW-1:0]   blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [r2h_pkg::HueW-1:0]  hue_o,
  output logic [r2h_pkg::ChW-1:0]   saturation_o,
  output logic [r2h_pkg::ChW-1:0]   value_o
);

  r2h_pkg::div_t                chain_dat [r2h_pkg::NumCells+1];
  logic [r2h_pkg::NumCells:0]   chain_vld;
  logic [r2h_pkg::NumCells:0]   chain_rdy;

  r2h_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .up_vld_i (in_valid_i),
    .up_rdy_o (in_ready_o),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .dn_vld_o (chain_vld[0]),
    .dn_rdy_i (chain_rdy[0]),
    .dn_dat_o (chain_dat[0])
  );

  for (genvar k = 0; k < r2h_pkg::NumCells; k++) begin : g_cell
    r2h_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .up_vld_i (chain_vld[k]),
      .up_rdy_o (chain_rdy[k]),
      .up_dat_i (chain_dat[k]),
      .dn_vld_o (chain_vld[k+1]),
      .dn_rdy_i (chain_rdy[k+1]),
      .dn_dat_o (chain_dat[k+1])
    );
  end

  assign chain_rdy[r2h_pkg::NumCells] = out_ready_i;

  assign out_valid_o  = chain_vld[r2h_pkg::NumCells];
  assign hue_o        = chain_dat[r2h_pkg::NumCells].hue_quo;
  assign saturation_o = chain_dat[r2h_pkg::NumCells].sat_quo[r2h_pkg::ChW-1:0];
  assign value_o      = chain_dat[r2h_pkg::NumCells].value;

endmodule

// File: hdl/rgb_to_hsv_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_chk: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsv_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [r2h_pkg::HueW-1:0]  hue_o,
  input logic [r2h_pkg::ChW-1:0]   saturation_o,
  input logic [r2h_pkg::ChW-1:0]   value_o
);

  // Hold a waiting input beat until it is taken.
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i)

  // Hold a stalled result beat unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(hue_o) && $stable(saturation_o) && $stable(value_o))

  // With the tail empty every stage can advance, so the input is open.
  `ASSERT_IMPLIES(a_ready_when_drained, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // Black pixels give zero hue and saturation.
  `ASSERT_IMPLIES(a_black_zero, clk_i, rst_ni, out_valid_o && (value_o == '0),
                  (hue_o == '0) && (saturation_o == '0))

  // A nonzero hue needs chroma, which always gives nonzero saturation.
  `ASSERT_IMPLIES(a_hue_has_sat, clk_i, rst_ni, out_valid_o && (hue_o != '0),
                  saturation_o != '0)

endmodule

bind rgb_to_hsv rgb_to_hsv_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .value_o      (value_o)
);

// File: tb/rgb_to_hsv_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_test: self-checking bench for the RGB to HSV converter
// Walks a table of corner pixels, then about 1400 random pixels with
// random gaps on the sender and random stalls on the receiver. Each
// accepted pixel queues its expected hue, saturation and value; each
// result beat is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module rgb_to_hsv_test;

  localparam int unsigned ClkHalf    = 2;
  localparam int unsigned RstCycles  = 12;
  localparam int unsigned PipeDepth  = 17;
  localparam int unsigned RandPixels = 1400;
  localparam int unsigned ChunkLen   = 100;
  localparam int unsigned MaxIdle    = 13;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    logic [r2h_pkg::HueW-1:0] hue;
    logic [r2h_pkg::ChW-1:0]  sat;
    logic [r2h_pkg::ChW-1:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [r2h_pkg::ChW-1:0] r;
    logic [r2h_pkg::ChW-1:0] g;
    logic [r2h_pkg::ChW-1:0] b;
    logic                    known;  // expected result typed in below
    hsv_t                    want;
  } pixel_row_t;

  localparam int unsigned NumRows = 22;

  // r, g, b, known, {hue, sat, val}
  pixel_row_t corner_rows [NumRows] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     8'd0,   8'd0}},   // black
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     8'd0,   8'd255}}, // white
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     8'd0,   8'd128}}, // gray
    '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0,     8'd0,   8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     8'd255, 8'd255}}, // red
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 8'd255, 8'd255}}, // green
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 8'd255, 8'd255}}, // blue
    '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 8'd255, 8'd255}}, // red ties green
    '{8'd0,   8'd255, 8'd255, 1'b1, '{16'd32768, 8'd255, 8'd255}}, // green ties blue
    '{8'd255, 8'd0,   8'd255, 1'b1, '{16'd54613, 8'd255, 8'd255}}, // red ties blue
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     8'd255, 8'd1}},
    '{8'd0,   8'd1,   8'd0,   1'b1, '{16'd21845, 8'd255, 8'd1}},
    '{8'd0,   8'd0,   8'd1,   1'b1, '{16'd43690, 8'd255, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // hue just short of a full turn
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd254, 8'd255, 8'd254, 1'b0, '0},
    '{8'd1,   8'd0,   8'd255, 1'b0, '0},
    '{8'd0,   8'd1,   8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd12,  8'd200, 8'd77,  1'b0, '0},
    '{8'd200, 8'd200, 8'd199, 1'b0, '0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_ready;
  logic [r2h_pkg::ChW-1:0]  red;
  logic [r2h_pkg::ChW-1:0]  green;
  logic [r2h_pkg::ChW-1:0]  blue;
  logic                     out_valid;
  logic                     out_ready;
  logic [r2h_pkg::HueW-1:0] hue;
  logic [r2h_pkg::ChW-1:0]  saturation;
  logic [r2h_pkg::ChW-1:0]  value;

  // payload tag: typed expectation travels with the beat
  logic  pix_known;
  hsv_t  pix_want;

  bit    tx_calm;
  bit    rx_calm;
  hsv_t  hsv_expected [$];
  int    mismatches;
  int    cycles;

  rgb_to_hsv i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hue_o       (hue),
    .saturation_o(saturation),
    .value_o     (value)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic hsv_t hsv_of(logic [r2h_pkg::ChW-1:0] r,
                                  logic [r2h_pkg::ChW-1:0] g,
                                  logic [r2h_pkg::ChW-1:0] b);
    int   ri, gi, bi, hi, lo, d, num;
    hsv_t res;
    ri = r;
    gi = g;
    bi = b;
    hi = (ri > gi) ? ri : gi;
    hi = (bi > hi) ? bi : hi;
    lo = (ri < gi) ? ri : gi;
    lo = (bi < lo) ? bi : lo;
    d = hi - lo;
    res = '0;
    res.val = hi[r2h_pkg::ChW-1:0];
    if (hi != 0) res.sat = r2h_pkg::ChW'((255 * d) / hi);
    if (d > 0) begin
      // red wins ties, then green
      if (hi == ri) num = gi - bi + ((gi < bi) ? 6 * d : 0);
      else if (hi == gi) num = bi - ri + 2 * d;
      else num = ri - gi + 4 * d;
      if (num < 0) num = 0;
      res.hue = r2h_pkg::HueW'((num * 65536) / (6 * d));
    end
    return res;
  endfunction

  function automatic int idle_draw(bit calm);
    return calm ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  task automatic report(string what, hsv_t want, hsv_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%s: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
               what, want.hue, want.sat, want.val, got.hue, got.sat, got.val);
  endtask

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with valid still high.
  task automatic send_pixel(logic [r2h_pkg::ChW-1:0] r, logic [r2h_pkg::ChW-1:0] g,
                            logic [r2h_pkg::ChW-1:0] b, logic known, hsv_t want);
    int gap;
    gap = idle_draw(tx_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    red       = r;
    green     = g;
    blue      = b;
    pix_known = known;
    pix_want  = want;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (hsv_expected.size() != 0) @(negedge clk_i);
  endtask

  // Queue on accepted input, check on accepted output.
  always @(posedge clk_i) begin : scoreboard
    hsv_t got;
    hsv_t want;
    if (rst_ni) begin
      if (in_valid && in_ready)
        hsv_expected.push_back(pix_known ? pix_want : hsv_of(red, green, blue));
      if (out_valid && out_ready) begin
        got = '{hue, saturation, value};
        if (hsv_expected.size() == 0) begin
          report("unexpected result beat", '0, got);
        end else begin
          want = hsv_expected.pop_front();
          if (got.hue != want.hue) report("hue mismatch", want, got);
          else if (got.sat != want.sat) report("saturation mismatch", want, got);
          else if (got.val != want.val) report("value mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL rgb_to_hsv");
      $finish;
    end
  end

  // Receiver: random stall before each result beat.
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_draw(rx_calm);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [r2h_pkg::ChW-1:0] r, g, b;
    int kind;
    mismatches = 0;
    cycles     = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    red        = '0;
    green      = '0;
    blue       = '0;
    pix_known  = 1'b0;
    pix_want   = '0;
    repeat (RstCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (corner_rows[i])
      send_pixel(corner_rows[i].r, corner_rows[i].g, corner_rows[i].b,
                 corner_rows[i].known, corner_rows[i].want);
    drain_results();

    for (int n = 0; n < RandPixels; n++) begin
      if (n % ChunkLen == 0) begin
        // first chunk streams back to back, second fills the pipe under stalls
        tx_calm = (n == 0) || (n == ChunkLen) || ($urandom_range(0, 2) == 0);
        rx_calm = (n == 0) || ((n != ChunkLen) && ($urandom_range(0, 2) == 0));
      end
      r = r2h_pkg::ChW'($urandom_range(0, 255));
      g = r2h_pkg::ChW'($urandom_range(0, 255));
      b = r2h_pkg::ChW'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      case (kind)
        6: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        7: begin
          g = r;
          b = r;
        end
        8: begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        9: begin
          // nearly gray: small chroma stresses the divider
          g = r + 8'($urandom_range(0, 2));
          b = r - 8'($urandom_range(0, 2));
        end
        default: ;
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end
    drain_results();
    repeat (2 * PipeDepth) @(posedge clk_i);

    if (mismatches == 0 && hsv_expected.size() == 0) begin
      $display("PASS rgb_to_hsv");
    end else begin
      $display("FAIL rgb_to_hsv");
    end
    $finish;
  end

endmodule
